>>> src/bcu_pkg.sv
// Shared types, constants and arithmetic helpers for the barometer compensation unit.
// No dependencies; every other file of the block except bcu_checker imports this package.
`default_nettype none

package bcu_pkg;

   localparam int DUT_W    = 25;
   localparam int OUT_W    = 21;
   localparam int CSR_W    = 20;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [16:0] SQUARE_LIMIT  = 17'sd46340;
   localparam logic signed [16:0] OFFSET_TC_REF = 17'sd1024;
   localparam logic signed [16:0] PRESSURE_BASE = 17'sd7168;
   localparam logic signed [23:0] TEMP_BASE     = 24'sd250;

   localparam logic signed [63:0] OUT_MAX = 64'sd1048575;
   localparam logic signed [63:0] OUT_MIN = -64'sd1048576;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SENSITIVITY = 3'd0,
      REG_OFFSET      = 3'd1,
      REG_SENS_TC     = 3'd2,
      REG_OFFSET_TC   = 3'd3,
      REG_REF_TEMP    = 3'd4,
      REG_TEMP_TC     = 3'd5,
      REG_FINE_OFFSET = 3'd6,
      REG_SHAPE       = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [15:0] sensitivity;
      logic [15:0] offset;
      logic [15:0] sens_tc;
      logic [15:0] offset_tc;
      logic [15:0] ref_temp;
      logic [15:0] temp_tc;
      logic [15:0] fine_offset;
      logic [5:0]  shape_a;
      logic [5:0]  shape_b;
      logic [3:0]  shape_c;
      logic [3:0]  shape_d;
      logic        bad;
   } cfg_type;

   typedef struct packed {
      logic                    valid;
      logic signed [DUT_W-1:0] dut;
      logic [15:0]             d1;
   } dut_beat_type;

   // signed shift that rounds toward zero
   function automatic logic signed [63:0] tdiv_pow2(input logic signed [63:0] x,
                                                    input logic [5:0] k);
      logic signed [63:0] bias;
      bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
      return (x + bias) >>> k;
   endfunction

   function automatic logic fits_int32(input logic signed [63:0] p);
      return (p >= -64'sd2147483648) && (p <= 64'sd2147483647);
   endfunction

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
      logic signed [63:0] c;
      c = v;
      if (c > OUT_MAX) c = OUT_MAX;
      if (c < OUT_MIN) c = OUT_MIN;
      return c[OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> src/bcu_csr.sv
// Calibration and shape registers with the range check that drives status.
// Depends on bcu_pkg.
`default_nettype none

module bcu_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [bcu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bcu_pkg::CSR_W-1:0]      csr_wdata,
   output bcu_pkg::cfg_type               cfg
);
   import bcu_pkg::*;

   localparam logic [15:0] SensMin   = 16'h0100;
   localparam logic [15:0] OffsetMax = 16'h1FFF;
   localparam logic [15:0] SensTcMax = 16'h0400;
   localparam logic [15:0] OffTcMax  = 16'h1000;
   localparam logic [15:0] RefMin    = 16'h1000;
   localparam logic [15:0] TempTcMax = 16'h4000;
   localparam logic [15:0] FineMin   = 16'h0960;
   localparam logic [15:0] FineMax   = 16'h0A28;

   logic [15:0] c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff, c7_ff;
   logic [19:0] shape_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff    <= '0;
         c2_ff    <= '0;
         c3_ff    <= '0;
         c4_ff    <= '0;
         c5_ff    <= '0;
         c6_ff    <= '0;
         c7_ff    <= '0;
         shape_ff <= '0;
      end else if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_SENSITIVITY: c1_ff    <= csr_wdata[15:0];
            REG_OFFSET:      c2_ff    <= csr_wdata[15:0];
            REG_SENS_TC:     c3_ff    <= csr_wdata[15:0];
            REG_OFFSET_TC:   c4_ff    <= csr_wdata[15:0];
            REG_REF_TEMP:    c5_ff    <= csr_wdata[15:0];
            REG_TEMP_TC:     c6_ff    <= csr_wdata[15:0];
            REG_FINE_OFFSET: c7_ff    <= csr_wdata[15:0];
            REG_SHAPE:       shape_ff <= csr_wdata;
            default:         shape_ff <= shape_ff;
         endcase
      end
   end

   always_comb begin
      cfg.sensitivity = c1_ff;
      cfg.offset      = c2_ff;
      cfg.sens_tc     = c3_ff;
      cfg.offset_tc   = c4_ff;
      cfg.ref_temp    = c5_ff;
      cfg.temp_tc     = c6_ff;
      cfg.fine_offset = c7_ff;
      cfg.shape_a     = shape_ff[5:0];
      cfg.shape_b     = shape_ff[11:6];
      cfg.shape_c     = shape_ff[15:12];
      cfg.shape_d     = shape_ff[19:16];
      cfg.bad = (c1_ff < SensMin) || (c2_ff > OffsetMax) || (c3_ff > SensTcMax) ||
                (c4_ff > OffTcMax) || (c5_ff < RefMin) || (c6_ff > TempTcMax) ||
                (c7_ff < FineMin) || (c7_ff > FineMax) ||
                (shape_ff[5:0] == 6'd0) || (shape_ff[11:6] == 6'd0) ||
                (shape_ff[15:12] == 4'd0) || (shape_ff[19:16] == 4'd0);
   end

endmodule

`default_nettype wire

>>> src/bcu_dut_pipe.sv
// Four-stage front pipe: temperature distance, second-order correction, corrected dT.
// Depends on bcu_pkg.
`default_nettype none

module bcu_dut_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [15:0]           raw_temperature,
   input  logic [15:0]           raw_pressure,
   input  bcu_pkg::cfg_type      cfg,
   output bcu_pkg::dut_beat_type beat_out
);
   import bcu_pkg::*;

   // stage 1: distance to reference, factor choice, square range
   logic signed [16:0] dist_in, dist1_ff;
   logic [5:0]         fac_in, fac1_ff;
   logic               small_in, small1_ff;
   logic [15:0]        d1_1_ff;
   logic               vld1_ff;

   // stage 2: square and factor products
   logic signed [33:0] sq_full;
   logic [30:0]        sq_in, sq2_ff;
   logic signed [23:0] df_in, df2_ff;
   logic signed [16:0] dist2_ff;
   logic [5:0]         fac2_ff;
   logic               small2_ff;
   logic [15:0]        d1_2_ff;
   logic               vld2_ff;

   // stage 3: second product
   logic [23:0]        sq_q;
   logic signed [16:0] df_q;
   logic signed [24:0] opa;
   logic signed [17:0] opb;
   logic signed [42:0] prod;
   logic [30:0]        term_in, term3_ff;
   logic signed [16:0] dist3_ff;
   logic [15:0]        d1_3_ff;
   logic               vld3_ff;

   // stage 4: scale and subtract
   logic [4:0]              shift;
   logic [30:0]             term;
   logic signed [DUT_W-1:0] dut_in, dut4_ff;
   logic [15:0]             d1_4_ff;
   logic                    vld4_ff;

   always_comb begin
      dist_in  = signed'({1'b0, raw_temperature}) - signed'({1'b0, cfg.ref_temp});
      fac_in   = (raw_temperature < cfg.ref_temp) ? cfg.shape_b : cfg.shape_a;
      small_in = (dist_in >= -SQUARE_LIMIT) && (dist_in <= SQUARE_LIMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) vld1_ff <= 1'b0;
      else if (advance) vld1_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dist1_ff  <= dist_in;
         fac1_ff   <= fac_in;
         small1_ff <= small_in;
         d1_1_ff   <= raw_pressure;
      end
   end

   always_comb begin
      sq_full = dist1_ff * dist1_ff;
      sq_in   = sq_full[30:0];
      df_in   = dist1_ff * signed'({1'b0, fac1_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) vld2_ff <= 1'b0;
      else if (advance) vld2_ff <= vld1_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq2_ff    <= sq_in;
         df2_ff    <= df_in;
         dist2_ff  <= dist1_ff;
         fac2_ff   <= fac1_ff;
         small2_ff <= small1_ff;
         d1_2_ff   <= d1_1_ff;
      end
   end

   // square fits 32 bits: divide the square, then scale by factor;
   // otherwise divide distance times factor, then scale by distance
   always_comb begin
      sq_q    = sq2_ff[30:7];
      df_q    = 17'(tdiv_pow2(64'(df2_ff), 6'd7));
      opa     = small2_ff ? signed'({1'b0, sq_q}) : 25'(df_q);
      opb     = small2_ff ? signed'({12'd0, fac2_ff}) : 18'(dist2_ff);
      prod    = opa * opb;
      term_in = prod[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) vld3_ff <= 1'b0;
      else if (advance) vld3_ff <= vld2_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         term3_ff <= term_in;
         dist3_ff <= dist2_ff;
         d1_3_ff  <= d1_2_ff;
      end
   end

   always_comb begin
      shift  = {1'b0, cfg.shape_c} + 5'd7;
      term   = term3_ff >> shift;
      dut_in = 25'(dist3_ff) - signed'({1'b0, term[23:0]});
   end

   always_ff @(posedge clock) begin
      if (reset) vld4_ff <= 1'b0;
      else if (advance) vld4_ff <= vld3_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dut4_ff <= dut_in;
         d1_4_ff <= d1_3_ff;
      end
   end

   assign beat_out.valid = vld4_ff;
   assign beat_out.dut   = dut4_ff;
   assign beat_out.d1    = d1_4_ff;

endmodule

`default_nettype wire

>>> src/bcu_comp_pipe.sv
// Seven-stage back pipe: offset, sensitivity, pressure and temperature, saturation.
// Depends on bcu_pkg; takes corrected dT beats from bcu_dut_pipe.
`default_nettype none

module bcu_comp_pipe (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  bcu_pkg::dut_beat_type              beat_in,
   input  bcu_pkg::cfg_type                   cfg,
   output logic                               out_valid,
   output logic signed [bcu_pkg::OUT_W-1:0]   pressure_out,
   output logic signed [bcu_pkg::OUT_W-1:0]   temperature_out,
   output logic                               status
);
   import bcu_pkg::*;

   // stage 5: products on dT
   logic signed [16:0]      k_off;
   logic signed [41:0]      poff_full, psens_full, pt_full;
   logic signed [8:0]       dq;
   logic signed [25:0]      qt_full;
   logic signed [35:0]      poff_in, poff5_ff;
   logic signed [34:0]      psens_in, psens5_ff;
   logic signed [DUT_W-1:0] qsens_in, qsens5_ff;
   logic signed [38:0]      pt_in, pt5_ff;
   logic signed [22:0]      qt_in, qt5_ff;
   logic signed [DUT_W-1:0] tdp_in, tdp5_ff;
   logic [15:0]             d1_5_ff;
   logic                    vld5_ff;

   // stage 6: offset, sensitivity, temperature
   logic signed [DUT_W-1:0] sens_q;
   logic signed [22:0]      temp_q;
   logic signed [24:0]      off_in, off6_ff;
   logic signed [25:0]      sens_in, sens6_ff;
   logic signed [23:0]      temp_in, temp6_ff;
   logic [15:0]             d1_6_ff;
   logic                    vld6_ff;

   // stage 7: pressure operands
   logic signed [16:0] dm_in, dm7_ff;
   logic signed [11:0] sq16_in, sq16_7_ff;
   logic signed [25:0] sens7_ff;
   logic [15:0]        d1_7_ff;
   logic signed [24:0] off7_ff;
   logic signed [23:0] temp7_ff;
   logic               vld7_ff;

   // stage 8: pressure products
   logic signed [42:0] m1_full, md_in, md8_ff;
   logic signed [28:0] m2_full;
   logic signed [41:0] m1_in, m1_8_ff;
   logic signed [27:0] m2_in, m2_8_ff;
   logic signed [24:0] off8_ff;
   logic signed [23:0] temp8_ff;
   logic               vld8_ff;

   // stage 9: raw pressure term
   logic signed [27:0] x_q;
   logic signed [28:0] x_in, x9_ff;
   logic signed [23:0] temp9_ff;
   logic               vld9_ff;

   // stage 10: times ten
   logic signed [32:0] x10_in, x10_ff;
   logic signed [23:0] temp10_ff;
   logic               vld10_ff;

   // stage 11: output register
   logic signed [29:0]       pres;
   logic signed [OUT_W-1:0]  pres_in, temp_in_sat;
   logic signed [OUT_W-1:0]  pres_ff, temp_ff;
   logic                     status_ff;
   logic                     vld11_ff;

   always_comb begin
      k_off      = signed'({1'b0, cfg.offset_tc}) - OFFSET_TC_REF;
      poff_full  = k_off * beat_in.dut;
      poff_in    = poff_full[35:0];
      psens_full = signed'({1'b0, cfg.sens_tc}) * beat_in.dut;
      psens_in   = psens_full[34:0];
      qsens_in   = cfg.sens_tc[10] ? beat_in.dut : '0;
      pt_full    = signed'({1'b0, cfg.temp_tc}) * beat_in.dut;
      pt_in      = pt_full[38:0];
      dq         = 9'(tdiv_pow2(64'(beat_in.dut), 6'd16));
      qt_full    = dq * signed'({1'b0, cfg.temp_tc});
      qt_in      = qt_full[22:0];
      tdp_in     = 25'(tdiv_pow2(64'(beat_in.dut), {2'b00, cfg.shape_d}));
   end

   always_ff @(posedge clock) begin
      if (reset) vld5_ff <= 1'b0;
      else if (advance) vld5_ff <= beat_in.valid;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         poff5_ff  <= poff_in;
         psens5_ff <= psens_in;
         qsens5_ff <= qsens_in;
         pt5_ff    <= pt_in;
         qt5_ff    <= qt_in;
         tdp5_ff   <= tdp_in;
         d1_5_ff   <= beat_in.d1;
      end
   end

   always_comb begin
      off_in  = 25'(signed'({1'b0, cfg.offset, 2'b00})) +
                25'(tdiv_pow2(64'(poff5_ff), 6'd12));
      sens_q  = fits_int32(64'(psens5_ff)) ? 25'(tdiv_pow2(64'(psens5_ff), 6'd10))
                                           : qsens5_ff;
      sens_in = 26'(signed'({1'b0, cfg.sensitivity})) + 26'(sens_q);
      temp_q  = fits_int32(64'(pt5_ff)) ? 23'(tdiv_pow2(64'(pt5_ff), 6'd16)) : qt5_ff;
      temp_in = TEMP_BASE + 24'(temp_q) - 24'(tdp5_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) vld6_ff <= 1'b0;
      else if (advance) vld6_ff <= vld5_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         off6_ff  <= off_in;
         sens6_ff <= sens_in;
         temp6_ff <= temp_in;
         d1_6_ff  <= d1_5_ff;
      end
   end

   always_comb begin
      dm_in   = signed'({1'b0, d1_6_ff}) - PRESSURE_BASE;
      sq16_in = 12'(tdiv_pow2(64'(sens6_ff), 6'd14));
   end

   always_ff @(posedge clock) begin
      if (reset) vld7_ff <= 1'b0;
      else if (advance) vld7_ff <= vld6_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dm7_ff    <= dm_in;
         sq16_7_ff <= sq16_in;
         sens7_ff  <= sens6_ff;
         d1_7_ff   <= d1_6_ff;
         off7_ff   <= off6_ff;
         temp7_ff  <= temp6_ff;
      end
   end

   always_comb begin
      m1_full = sens7_ff * dm7_ff;
      m1_in   = m1_full[41:0];
      m2_full = sq16_7_ff * dm7_ff;
      m2_in   = m2_full[27:0];
      md_in   = sens7_ff * signed'({1'b0, d1_7_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) vld8_ff <= 1'b0;
      else if (advance) vld8_ff <= vld7_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_8_ff  <= m1_in;
         m2_8_ff  <= m2_in;
         md8_ff   <= md_in;
         off8_ff  <= off7_ff;
         temp8_ff <= temp7_ff;
      end
   end

   always_comb begin
      x_q  = fits_int32(64'(md8_ff)) ? 28'(tdiv_pow2(64'(m1_8_ff), 6'd14)) : m2_8_ff;
      x_in = 29'(x_q) - 29'(off8_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) vld9_ff <= 1'b0;
      else if (advance) vld9_ff <= vld8_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x9_ff    <= x_in;
         temp9_ff <= temp8_ff;
      end
   end

   assign x10_in = (33'(x9_ff) <<< 3) + (33'(x9_ff) <<< 1);

   always_ff @(posedge clock) begin
      if (reset) vld10_ff <= 1'b0;
      else if (advance) vld10_ff <= vld9_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x10_ff    <= x10_in;
         temp10_ff <= temp9_ff;
      end
   end

   always_comb begin
      pres        = 30'(tdiv_pow2(64'(x10_ff), 6'd5)) + 30'(signed'({1'b0, cfg.fine_offset}));
      pres_in     = cfg.bad ? '0 : sat_out(64'(pres));
      temp_in_sat = cfg.bad ? '0 : sat_out(64'(temp10_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) vld11_ff <= 1'b0;
      else if (advance) vld11_ff <= vld10_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pres_ff   <= pres_in;
         temp_ff   <= temp_in_sat;
         status_ff <= cfg.bad;
      end
   end

   assign out_valid       = vld11_ff;
   assign pressure_out    = pres_ff;
   assign temperature_out = temp_ff;
   assign status          = status_ff;

endmodule

`default_nettype wire

>>> src/barometer_compensation_unit.sv
// Barometer compensation unit: 11-stage pipeline from accepted request beat to response
// beat, one beat per cycle sustained; the whole pipe holds only while a finished response
// beat waits on rsp_ready, which sets req_ready.
// Reset clears every stage valid bit and all calibration registers to zero, so status
// reads 1 with zero results until a valid calibration is written.
// Depends on bcu_pkg, bcu_csr, bcu_dut_pipe, bcu_comp_pipe.
`default_nettype none

module barometer_compensation_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [15:0]                         req_raw_temperature,
   input  logic [15:0]                         req_raw_pressure,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [bcu_pkg::OUT_W-1:0]    rsp_pressure_out,
   output logic signed [bcu_pkg::OUT_W-1:0]    rsp_temperature_out,
   output logic                                rsp_status,
   input  logic                                csr_wr_en,
   input  logic [bcu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bcu_pkg::CSR_W-1:0]           csr_wdata
);
   import bcu_pkg::*;

   cfg_type      cfg;
   dut_beat_type dut_beat;
   logic         advance;

   // advance everything unless the output beat is held
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   bcu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bcu_dut_pipe u_dut_pipe (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .in_valid        (req_valid),
      .raw_temperature (req_raw_temperature),
      .raw_pressure    (req_raw_pressure),
      .cfg             (cfg),
      .beat_out        (dut_beat)
   );

   bcu_comp_pipe u_comp_pipe (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .beat_in         (dut_beat),
      .cfg             (cfg),
      .out_valid       (rsp_valid),
      .pressure_out    (rsp_pressure_out),
      .temperature_out (rsp_temperature_out),
      .status          (rsp_status)
   );

endmodule

`default_nettype wire

>>> src/bcu_checker.sv
// Port-level assertions for barometer_compensation_unit, attached by bind.
// Depends on barometer_compensation_unit port names.
`default_nettype none

module bcu_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [20:0] rsp_pressure_out,
   input logic signed [20:0] rsp_temperature_out,
   input logic               rsp_status
);

   a_status_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> (rsp_pressure_out == 21'sd0) &&
                                  (rsp_temperature_out == 21'sd0))
      else $error("status beat carries nonzero results");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pressure_out) &&
                                  $stable(rsp_temperature_out) && $stable(rsp_status))
      else $error("held response beat changed");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   a_ready_when_drain : assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while output drains");

endmodule

bind barometer_compensation_unit bcu_checker u_bcu_checker (.*);

`default_nettype wire
